// ===== hdl/pfpsc_pkg.sv =====
// ----------------------------------------------------------------------------
// pfpsc_pkg
// Types, constants and tables shared by the path-follow pedal/steer controller.
// ----------------------------------------------------------------------------
package pfpsc_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int STEP_W       = $clog2(CORDIC_STEPS + 1);

    localparam logic signed [27:0] PI24     = 28'sd52707179;
    localparam logic signed [27:0] HALFPI24 = 28'sd26353589;
    localparam logic signed [17:0] PI13     = 18'sd25736;
    localparam logic signed [17:0] TWOPI13  = 18'sd51472;
    localparam logic [16:0]        INVK16   = 17'd39796;
    localparam logic [17:0]        HEAD_TOL13 = 18'd1393;
    localparam logic [17:0]        AIM_TOL13  = 18'd2458;
    localparam logic [31:0]        NEAR_Q8    = 32'd2560;
    localparam int                 PEDAL_MAX  = 25600;

    localparam int CFG_IDX_W = 3;
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TIME_STEP   = 3'd0,
        REG_SPEED_TOL   = 3'd1,
        REG_ACCEL_P     = 3'd2,
        REG_ACCEL_D     = 3'd3,
        REG_BRAKE_GAIN  = 3'd4
    } t_reg_idx;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD_AIM,     // set up vectoring on aim error
        ST_RUN_AIM,
        ST_LOAD_DES,     // set up vectoring on aim-to-aim vector
        ST_RUN_DES,
        ST_LOAD_ROT,     // set up rotation by -heading
        ST_RUN_ROT,
        ST_DECIDE,       // distance, heading errors, branch choice
        ST_EXP,          // 1-exp(-d) steps
        ST_PEDAL1,
        ST_PEDAL2,
        ST_PEDAL3,
        ST_OUT
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;      // latch input transaction
        logic load_vec;     // load CORDIC in vectoring mode
        logic sel_des;      // vector source is aim minus previous aim
        logic load_rot;     // load CORDIC in rotation mode
        logic step;         // one CORDIC iteration
        logic decide;
        logic exp_step;
        logic pedal1;
        logic pedal2;
        logic pedal3;
        logic commit;       // update history, present result
    } t_cmd;

    typedef struct packed {
        logic cordic_done;
        logic exp_done;
    } t_stat;

    function automatic logic signed [27:0] atan_lut(input logic [4:0] i);
        logic signed [27:0] r;
        unique case (i)
            5'd0:  r = 28'sd13176795;
            5'd1:  r = 28'sd7778716;
            5'd2:  r = 28'sd4110060;
            5'd3:  r = 28'sd2086331;
            5'd4:  r = 28'sd1047214;
            5'd5:  r = 28'sd524117;
            5'd6:  r = 28'sd262123;
            5'd7:  r = 28'sd131069;
            default: r = (i < 5'd24) ? (28'sd65536 >>> (i - 5'd8)) : 28'sd0;
        endcase
        return r;
    endfunction

    function automatic logic [16:0] exp_int_lut(input logic [3:0] n);
        logic [16:0] r;
        unique case (n)
            4'd0:  r = 17'd65536;
            4'd1:  r = 17'd24110;
            4'd2:  r = 17'd8869;
            4'd3:  r = 17'd3263;
            4'd4:  r = 17'd1200;
            4'd5:  r = 17'd442;
            4'd6:  r = 17'd162;
            4'd7:  r = 17'd60;
            4'd8:  r = 17'd22;
            4'd9:  r = 17'd8;
            4'd10: r = 17'd3;
            4'd11: r = 17'd1;
            default: r = 17'd0;
        endcase
        return r;
    endfunction

    function automatic logic [15:0] exp_frac_lut(input logic [2:0] i);
        logic [15:0] r;
        unique case (i)
            3'd0: r = 16'd39750;
            3'd1: r = 16'd51039;
            3'd2: r = 16'd57835;
            3'd3: r = 16'd61565;
            3'd4: r = 16'd63520;
            3'd5: r = 16'd64520;
            3'd6: r = 16'd65026;
            default: r = 16'd65280;
        endcase
        return r;
    endfunction

endpackage

// ===== hdl/pfpsc_if.sv =====
// ----------------------------------------------------------------------------
// pfpsc_in_if / pfpsc_out_if
// Valid/ready channels carrying one control tick and one pedal/steer result.
// ----------------------------------------------------------------------------
interface pfpsc_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] aim_x;
    logic signed [31:0] aim_y;
    logic [15:0]        aim_speed;
    logic signed [31:0] car_x;
    logic signed [31:0] car_y;
    logic signed [15:0] car_heading;
    logic [15:0]        car_speed;
    logic [14:0]        gas_now;
    logic [14:0]        brake_now;
    modport source (output valid, aim_x, aim_y, aim_speed, car_x, car_y, car_heading,
                    car_speed, gas_now, brake_now, input ready);
    modport sink   (input valid, aim_x, aim_y, aim_speed, car_x, car_y, car_heading,
                    car_speed, gas_now, brake_now, output ready);
endinterface

interface pfpsc_out_if;
    logic               valid;
    logic               ready;
    logic [14:0]        gas_cmd;
    logic [14:0]        brake_cmd;
    logic signed [15:0] steer_cmd;
    modport source (output valid, gas_cmd, brake_cmd, steer_cmd, input ready);
    modport sink   (input valid, gas_cmd, brake_cmd, steer_cmd, output ready);
endinterface

// ===== hdl/pfpsc_ctrl.sv =====
// ----------------------------------------------------------------------------
// pfpsc_ctrl
// Sequencer: walks one tick through the CORDIC passes and the pedal math.
// ----------------------------------------------------------------------------
module pfpsc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  pfpsc_pkg::t_stat  i_stat,
    output pfpsc_pkg::t_cmd   o_cmd
);

    pfpsc_pkg::t_state r_state, n_state;
    logic              r_out_valid, n_out_valid;

    // state and output-valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pfpsc_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // output register frees up while the next tick is computed
    assign o_in_ready  = (r_state == pfpsc_pkg::ST_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        if (r_out_valid && i_out_ready) n_out_valid = 1'b0;
        unique case (r_state)
            pfpsc_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state = pfpsc_pkg::ST_LOAD_AIM;
                end
            end
            pfpsc_pkg::ST_LOAD_AIM: begin
                o_cmd.load_vec = 1'b1;
                n_state = pfpsc_pkg::ST_RUN_AIM;
            end
            pfpsc_pkg::ST_RUN_AIM: begin
                o_cmd.step = 1'b1;
                if (i_stat.cordic_done) n_state = pfpsc_pkg::ST_LOAD_DES;
            end
            pfpsc_pkg::ST_LOAD_DES: begin
                o_cmd.load_vec = 1'b1;
                o_cmd.sel_des  = 1'b1;
                n_state = pfpsc_pkg::ST_RUN_DES;
            end
            pfpsc_pkg::ST_RUN_DES: begin
                o_cmd.step = 1'b1;
                if (i_stat.cordic_done) n_state = pfpsc_pkg::ST_LOAD_ROT;
            end
            pfpsc_pkg::ST_LOAD_ROT: begin
                o_cmd.load_rot = 1'b1;
                n_state = pfpsc_pkg::ST_RUN_ROT;
            end
            pfpsc_pkg::ST_RUN_ROT: begin
                o_cmd.step = 1'b1;
                if (i_stat.cordic_done) n_state = pfpsc_pkg::ST_DECIDE;
            end
            pfpsc_pkg::ST_DECIDE: begin
                o_cmd.decide = 1'b1;
                n_state = pfpsc_pkg::ST_EXP;
            end
            pfpsc_pkg::ST_EXP: begin
                o_cmd.exp_step = 1'b1;
                if (i_stat.exp_done) n_state = pfpsc_pkg::ST_PEDAL1;
            end
            pfpsc_pkg::ST_PEDAL1: begin
                o_cmd.pedal1 = 1'b1;
                n_state = pfpsc_pkg::ST_PEDAL2;
            end
            pfpsc_pkg::ST_PEDAL2: begin
                o_cmd.pedal2 = 1'b1;
                n_state = pfpsc_pkg::ST_PEDAL3;
            end
            pfpsc_pkg::ST_PEDAL3: begin
                o_cmd.pedal3 = 1'b1;
                n_state = pfpsc_pkg::ST_OUT;
            end
            pfpsc_pkg::ST_OUT: begin
                // wait for the output register to be free
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.commit = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = pfpsc_pkg::ST_IDLE;
                end
            end
            default: n_state = pfpsc_pkg::ST_IDLE;
        endcase
    end

endmodule

// ===== hdl/pfpsc_dp.sv =====
// ----------------------------------------------------------------------------
// pfpsc_dp
// Datapath: shared CORDIC, exponential stepper, pedal arithmetic, history.
// ----------------------------------------------------------------------------
module pfpsc_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pfpsc_pkg::t_cmd    i_cmd,
    output pfpsc_pkg::t_stat   o_stat,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [15:0]        i_cfg_data,
    input  logic signed [31:0] i_aim_x,
    input  logic signed [31:0] i_aim_y,
    input  logic [15:0]        i_aim_speed,
    input  logic signed [31:0] i_car_x,
    input  logic signed [31:0] i_car_y,
    input  logic signed [15:0] i_car_heading,
    input  logic [15:0]        i_car_speed,
    input  logic [14:0]        i_gas_now,
    input  logic [14:0]        i_brake_now,
    output logic [14:0]        o_gas_cmd,
    output logic [14:0]        o_brake_cmd,
    output logic signed [15:0] o_steer_cmd
);

    localparam int CW = 56;   // CORDIC word: 33-bit error << 16 plus growth

    // configuration
    logic [15:0] r_time_step, r_speed_tol, r_accel_p, r_accel_d, r_brake_gain;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_step  <= 16'd655;
            r_speed_tol  <= 16'd18842;
            r_accel_p    <= 16'd197;
            r_accel_d    <= 16'd6400;
            r_brake_gain <= 16'd26214;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                pfpsc_pkg::REG_TIME_STEP:  r_time_step  <= i_cfg_data;
                pfpsc_pkg::REG_SPEED_TOL:  r_speed_tol  <= i_cfg_data;
                pfpsc_pkg::REG_ACCEL_P:    r_accel_p    <= i_cfg_data;
                pfpsc_pkg::REG_ACCEL_D:    r_accel_d    <= i_cfg_data;
                pfpsc_pkg::REG_BRAKE_GAIN: r_brake_gain <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // history
    logic signed [31:0] r_prev_ax, r_prev_ay;
    logic [31:0]        r_prev_dist;

    // captured transaction
    logic signed [31:0] r_ax, r_ay;
    logic signed [32:0] r_ex, r_ey;
    logic [15:0]        r_aspd, r_cspd;
    logic signed [15:0] r_head;
    logic [14:0]        r_gas_now, r_brake_now;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_ax        <= i_aim_x;
            r_ay        <= i_aim_y;
            r_ex        <= 33'(i_aim_x) - 33'(i_car_x);
            r_ey        <= 33'(i_aim_y) - 33'(i_car_y);
            r_aspd      <= i_aim_speed;
            r_cspd      <= i_car_speed;
            r_head      <= i_car_heading;
            r_gas_now   <= i_gas_now;
            r_brake_now <= i_brake_now;
        end
    end

    // ---------------- shared CORDIC ----------------
    logic signed [CW-1:0] r_cx, r_cy;
    logic signed [27:0]   r_cz;
    logic                 r_rot;
    logic                 r_zero;
    logic [pfpsc_pkg::STEP_W-1:0] r_cnt;
    logic signed [CW-1:0] r_mag_aim, r_steer_y;
    logic signed [27:0]   r_ang_aim, r_ang_des;
    logic                 r_pass;    // 0: aim pass next to finish, 1: desired pass

    logic signed [32:0] des_x, des_y, src_x, src_y;
    logic signed [CW-1:0] ld_x, ld_y;
    logic signed [27:0] rz0, rz1;
    logic signed [CW-1:0] shx, shy;
    logic dir_pos;
    logic [4:0] step_idx;

    assign des_x = 33'(r_ax) - 33'(r_prev_ax);
    assign des_y = 33'(r_ay) - 33'(r_prev_ay);
    assign src_x = i_cmd.sel_des ? des_x : r_ex;
    assign src_y = i_cmd.sel_des ? des_y : r_ey;
    assign ld_x  = CW'(src_x) <<< 16;
    assign ld_y  = CW'(src_y) <<< 16;

    // rotation start angle: -heading*2048 wrapped twice
    always_comb begin
        rz0 = -(28'(r_head) <<< 11);
        for (int k = 0; k < 2; k++) begin
            if (rz0 > pfpsc_pkg::PI24) rz0 = rz0 - (pfpsc_pkg::PI24 <<< 1);
            else if (rz0 < -pfpsc_pkg::PI24) rz0 = rz0 + (pfpsc_pkg::PI24 <<< 1);
        end
        rz1 = rz0;
    end

    assign step_idx = 5'(r_cnt);
    assign shx      = r_cx >>> step_idx;
    assign shy      = r_cy >>> step_idx;
    assign dir_pos  = r_rot ? (r_cz >= 0) : !(r_cy > 0);
    assign o_stat.cordic_done = (r_cnt == pfpsc_pkg::STEP_W'(pfpsc_pkg::CORDIC_STEPS - 1))
                                && i_cmd.step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_pass <= 1'b0;
        end else if (i_cmd.load_vec || i_cmd.load_rot) begin
            r_cnt <= '0;
            if (i_cmd.load_vec) r_pass <= i_cmd.sel_des;
        end else if (i_cmd.step && !r_zero) begin
            r_cnt <= r_cnt + 1'b1;
        end else if (i_cmd.step) begin
            r_cnt <= r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_vec) begin
            r_rot  <= 1'b0;
            r_zero <= (src_x == 0) && (src_y == 0);
            if (ld_x < 0) begin
                r_cz <= (ld_y >= 0) ? pfpsc_pkg::PI24 : -pfpsc_pkg::PI24;
                r_cx <= -ld_x;
                r_cy <= -ld_y;
            end else begin
                r_cz <= '0;
                r_cx <= ld_x;
                r_cy <= ld_y;
            end
        end else if (i_cmd.load_rot) begin
            r_rot  <= 1'b1;
            r_zero <= 1'b0;
            if (rz1 > pfpsc_pkg::HALFPI24) begin
                r_cz <= rz1 - pfpsc_pkg::PI24;
                r_cx <= -(CW'(r_ex) <<< 16);
                r_cy <= -(CW'(r_ey) <<< 16);
            end else if (rz1 < -pfpsc_pkg::HALFPI24) begin
                r_cz <= rz1 + pfpsc_pkg::PI24;
                r_cx <= -(CW'(r_ex) <<< 16);
                r_cy <= -(CW'(r_ey) <<< 16);
            end else begin
                r_cz <= rz1;
                r_cx <= CW'(r_ex) <<< 16;
                r_cy <= CW'(r_ey) <<< 16;
            end
        end else if (i_cmd.step) begin
            if (dir_pos) begin
                r_cx <= r_cx - shy;
                r_cy <= r_cy + shx;
                r_cz <= r_rot ? r_cz - pfpsc_pkg::atan_lut(step_idx)
                              : r_cz - pfpsc_pkg::atan_lut(step_idx);
            end else begin
                r_cx <= r_cx + shy;
                r_cy <= r_cy - shx;
                r_cz <= r_cz + pfpsc_pkg::atan_lut(step_idx);
            end
            if (o_stat.cordic_done) begin
                if (r_rot) r_steer_y <= dir_pos ? r_cy + shx : r_cy - shx;
                else if (!r_pass) begin
                    r_mag_aim <= r_zero ? '0 : (dir_pos ? r_cx - shy : r_cx + shy);
                    r_ang_aim <= r_zero ? '0 : (dir_pos ? r_cz - pfpsc_pkg::atan_lut(step_idx)
                                                        : r_cz + pfpsc_pkg::atan_lut(step_idx));
                end else begin
                    r_ang_des <= r_zero ? '0 : (dir_pos ? r_cz - pfpsc_pkg::atan_lut(step_idx)
                                                        : r_cz + pfpsc_pkg::atan_lut(step_idx));
                end
            end
        end
    end

    // ---------------- decide ----------------
    logic signed [CW-9:0] mag_s8;
    logic signed [CW+8:0] mag_prod;
    logic signed [CW+8:0] dist_full;
    logic [31:0]          r_dist;
    logic signed [17:0]   ah13, dh13, eh, ea, r_eh, r_ea;
    logic                 r_ahead, r_over;

    function automatic logic signed [17:0] wrap13(input logic signed [17:0] d);
        logic signed [17:0] v;
        v = d;
        for (int k = 0; k < 2; k++) begin
            if (v > pfpsc_pkg::PI13) v = v - pfpsc_pkg::TWOPI13;
            else if (v < -pfpsc_pkg::PI13) v = v + pfpsc_pkg::TWOPI13;
        end
        return v;
    endfunction

    assign mag_s8   = r_mag_aim[CW-1:8];
    assign mag_prod = (CW+9)'(mag_s8) * (CW+9)'($signed({1'b0, pfpsc_pkg::INVK16}));
    assign dist_full = (mag_prod + (CW+9)'(64'sd1 <<< 23)) >>> 24;
    assign ah13 = 18'((r_ang_aim + 28'sd1024) >>> 11);
    assign dh13 = 18'((r_ang_des + 28'sd1024) >>> 11);
    assign eh   = wrap13(dh13 - 18'(r_head));
    assign ea   = wrap13(ah13 - 18'(r_head));

    logic [31:0]  dist_c;
    assign dist_c = (dist_full < 0) ? 32'd0 :
                    (dist_full > (CW+9)'(64'hFFFFFFFF)) ? 32'hFFFFFFFF : dist_full[31:0];

    logic [17:0] abs_eh, abs_ea;
    assign abs_eh = eh[17] ? 18'(-eh) : 18'(eh);
    assign abs_ea = ea[17] ? 18'(-ea) : 18'(ea);

    always_ff @(posedge i_clk) begin
        if (i_cmd.decide) begin
            r_dist  <= dist_c;
            r_eh    <= eh;
            r_ea    <= ea;
            r_ahead <= (abs_eh < pfpsc_pkg::HEAD_TOL13) && (abs_ea > pfpsc_pkg::AIM_TOL13)
                       && (dist_c < pfpsc_pkg::NEAR_Q8);
            r_over  <= ({16'd0, r_cspd} << 14) > (32'(r_aspd) * 32'(r_speed_tol));
        end
    end

    // ---------------- exp stepper ----------------
    logic [16:0] r_e;
    logic [3:0]  r_ecnt;
    logic [33:0] e_prod;
    logic [2:0]  ebit;
    assign ebit   = 3'(r_ecnt - 4'd1);
    assign e_prod = 34'(r_e) * 34'(pfpsc_pkg::exp_frac_lut(ebit)) + 34'd32768;
    assign o_stat.exp_done = i_cmd.exp_step && (r_ecnt == 4'd8);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ecnt <= '0;
        end else if (i_cmd.decide) begin
            r_ecnt <= '0;
        end else if (i_cmd.exp_step) begin
            r_ecnt <= o_stat.exp_done ? 4'd0 : r_ecnt + 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exp_step) begin
            if (r_ecnt == 4'd0)
                r_e <= pfpsc_pkg::exp_int_lut(r_dist[11:8]);
            else if (r_dist[5'(4'd8 - r_ecnt)])
                r_e <= e_prod[32:16];
        end
    end

    // ---------------- pedal arithmetic ----------------
    logic        [16:0] f;
    assign f = (r_dist[31:8] >= 24'd12) ? 17'd65536 : 17'(17'd65536 - r_e);

    logic signed [48:0] r_p, r_d;
    logic [32:0]        r_gf;
    logic [31:0]        r_k;
    logic signed [49:0] r_sum;
    logic signed [64:0] r_ts_prod;
    logic signed [49:0] sum_raw;
    logic signed [48:0] sum_c;
    logic signed [33:0] ddist;
    logic signed [16:0] dspd;

    assign ddist   = 34'(r_dist) - 34'(r_prev_dist);
    assign sum_raw = 50'(r_p >>> 8) + 50'(r_d);
    assign sum_c   = (sum_raw > 50'sd70368744177664) ? 49'sd70368744177664 :
                     (sum_raw < -50'sd70368744177664) ? -49'sd70368744177664 : 49'(sum_raw);
    assign dspd    = 17'(r_aspd) - 17'(r_cspd);

    logic signed [40:0] r_gas, r_brake;

    always_ff @(posedge i_clk) begin
        if (i_cmd.pedal1) begin
            r_p  <= 49'($signed({1'b0, r_accel_p}) * $signed({1'b0, r_dist}));
            r_d  <= 49'($signed({1'b0, r_accel_d}) * ddist);
            r_gf <= 33'(r_gas_now) * 33'(f) + 33'd32768;
            r_k  <= 32'(r_brake_gain) * 32'(r_time_step);
        end
        if (i_cmd.pedal2) begin
            r_sum     <= 50'(sum_c);
            r_ts_prod <= 65'($signed({1'b0, r_k}) * -dspd) + 65'(64'sd1 <<< 31);
        end
        if (i_cmd.pedal3) begin
            if (r_ahead) begin
                r_gas   <= '0;
                r_brake <= 41'(r_brake_now) + 41'((33'(r_k) + 33'd8388608) >> 24);
            end else if (r_over) begin
                r_gas   <= '0;
                r_brake <= 41'(r_brake_now) + 41'(r_ts_prod >>> 32);
            end else begin
                r_gas   <= 41'(r_gf[32:16]) +
                           41'((67'(r_sum) * 67'($signed({1'b0, r_time_step}))
                                + 67'(64'sd1 <<< 23)) >>> 24);
                r_brake <= '0;
            end
        end
    end

    function automatic logic [14:0] sat_pedal(input logic signed [40:0] v);
        if (v < 0) return 15'd0;
        if (v > 41'(pfpsc_pkg::PEDAL_MAX)) return 15'(pfpsc_pkg::PEDAL_MAX);
        return v[14:0];
    endfunction

    // steering descale
    logic signed [CW-9:0] st_s8;
    logic signed [CW+8:0] st_prod, st_d;
    assign st_s8   = r_steer_y[CW-1:8];
    assign st_prod = (CW+9)'(st_s8) * (CW+9)'($signed({1'b0, pfpsc_pkg::INVK16}));
    assign st_d    = (st_prod + (CW+9)'(64'sd1 <<< 23)) >>> 24;

    logic signed [CW+8:0] r_st_d;
    always_ff @(posedge i_clk) begin
        if (i_cmd.pedal1) r_st_d <= st_d;
    end

    // commit: history and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_ax   <= '0;
            r_prev_ay   <= '0;
            r_prev_dist <= '0;
        end else if (i_cmd.commit) begin
            r_prev_ax   <= r_ax;
            r_prev_ay   <= r_ay;
            r_prev_dist <= r_dist;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            o_gas_cmd   <= sat_pedal(r_gas);
            o_brake_cmd <= sat_pedal(r_brake);
            if (r_st_d > (CW+9)'(pfpsc_pkg::PEDAL_MAX))
                o_steer_cmd <= 16'(pfpsc_pkg::PEDAL_MAX);
            else if (r_st_d < -(CW+9)'(pfpsc_pkg::PEDAL_MAX))
                o_steer_cmd <= -16'(pfpsc_pkg::PEDAL_MAX);
            else
                o_steer_cmd <= r_st_d[15:0];
        end
    end

endmodule

// ===== hdl/path_follow_pedal_steer_control.sv =====
// ----------------------------------------------------------------------------
// path_follow_pedal_steer_control
// Path-follow controller: pedal and steering commands from aim and pose.
// ----------------------------------------------------------------------------
// Channel  Dir  Payload
// in_ch    in   aim_x/y, aim_speed, car_x/y, car_heading, car_speed, gas/brake_now
// out_ch   out  gas_cmd, brake_cmd, steer_cmd
// cfg      in   i_cfg_we, i_cfg_idx, i_cfg_data (5 registers)
//
// A tick runs through the three passes of the shared CORDIC and the 9-step
// exponential stepper. Synchronous active-low reset; control, configuration
// and history registers return to their defaults.
// A held result stalls only the final commit; the next tick is accepted
// as soon as the previous one has committed.
module path_follow_pedal_steer_control (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    pfpsc_in_if.sink    in_ch,
    pfpsc_out_if.source out_ch
);

    pfpsc_pkg::t_cmd  cmd;
    pfpsc_pkg::t_stat stat;

    pfpsc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_ch.valid),
        .o_in_ready  (in_ch.ready),
        .o_out_valid (out_ch.valid),
        .i_out_ready (out_ch.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    pfpsc_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_aim_x       (in_ch.aim_x),
        .i_aim_y       (in_ch.aim_y),
        .i_aim_speed   (in_ch.aim_speed),
        .i_car_x       (in_ch.car_x),
        .i_car_y       (in_ch.car_y),
        .i_car_heading (in_ch.car_heading),
        .i_car_speed   (in_ch.car_speed),
        .i_gas_now     (in_ch.gas_now),
        .i_brake_now   (in_ch.brake_now),
        .o_gas_cmd     (out_ch.gas_cmd),
        .o_brake_cmd   (out_ch.brake_cmd),
        .o_steer_cmd   (out_ch.steer_cmd)
    );

endmodule

// ===== hdl/pfpsc_checker.sv =====
// ----------------------------------------------------------------------------
// pfpsc_sva
// Port-level checks on the controller's channels, bound to the top level.
// ----------------------------------------------------------------------------
module pfpsc_sva (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [14:0] gas_cmd,
    input logic [14:0] brake_cmd,
    input logic signed [15:0] steer_cmd
);

    // a transaction in is never accepted in the next cycle
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input accepted twice in a row");

    // pedals stay in range while a result is shown
    a_pedal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> (gas_cmd <= 15'd25600 && brake_cmd <= 15'd25600))
        else $error("pedal command out of range");

    // never gas and brake together
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> (gas_cmd == 15'd0 || brake_cmd == 15'd0))
        else $error("gas and brake both applied");

    // a stalled result stays valid and keeps its steering command
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(steer_cmd)))
        else $error("stalled result changed");

endmodule

bind path_follow_pedal_steer_control pfpsc_sva u_chk (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .gas_cmd   (out_ch.gas_cmd),
    .brake_cmd (out_ch.brake_cmd),
    .steer_cmd (out_ch.steer_cmd)
);
